// ===== hw/rtl/sfr_pkg.sv =====
// Shared types and constants for the ST frame receiver.
package sfr_pkg;

  // Header and type byte codes
  localparam logic [7:0] SYNC_S      = 8'h53;
  localparam logic [7:0] SYNC_T      = 8'h54;
  localparam logic [7:0] TYPE_ORDER  = 8'h79;
  localparam logic [7:0] TYPE_CMD    = 8'h43;
  localparam logic [7:0] TYPE_BRIGHT = 8'h42;
  localparam logic [3:0] NIB_MASK    = 4'hf;

  // Number of payload entries kept per frame
  localparam int unsigned HEAD_DEPTH = 3;
  localparam logic [7:0]  HEAD_LIMIT = 8'(HEAD_DEPTH);

  // Reported frame kinds
  typedef enum logic [1:0] {
    KIND_ORDER  = 2'd0,
    KIND_CMD    = 2'd1,
    KIND_BRIGHT = 2'd2
  } kind_t;

  // Receiver phase
  typedef enum logic [2:0] {
    PH_HUNT_S  = 3'd0,
    PH_WANT_T  = 3'd1,
    PH_TYPE    = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_TRAILER = 3'd5
  } phase_t;

  // One frame summary, parser to output stage
  typedef struct packed {
    kind_t      kind;
    logic       light_update;
    logic [7:0] entry_count;
    logic [7:0] trailer_value;
    logic [7:0] light_id;
    logic [7:0] light_level;
    logic [7:0] light_offset;
  } result_t;

endpackage

// ===== hw/rtl/st_frame_receiver.sv =====
// Top level of the ST frame receiver: byte stream in, frame summaries out.
//
//  channel  dir  signals                       content
//  s_*      in   s_tvalid s_tready s_tdata     received bytes
//  m_*      out  m_tvalid m_tready m_tdata     one summary per complete frame
//                m_tuser
//
// One byte is taken every cycle while the output register is empty or being
// drained; the parser state machine updates in the same cycle.
// A summary appears in the output register in the cycle after its trailer byte is accepted.
// A held summary stalls the input only when m_tready is low.
// rst is synchronous and returns the parser to hunting for the S byte.
module st_frame_receiver
  import sfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] entry_count, [15:8] trailer_value,
                                 // [23:16] light_id, [31:24] light_level,
                                 // [39:32] light_offset
  output logic [2:0]  m_tuser    // [1:0] frame_kind, [2] light_update
);

  logic    accept;
  logic    res_valid;
  result_t res;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  sfr_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (s_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tdata <= {res.light_offset, res.light_level, res.light_id,
                  res.trailer_value, res.entry_count};
      m_tuser <= {res.light_update, res.kind};
    end
  end

  // Kind code three is never reported
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tuser[1:0] != 2'd3)
    else $error("invalid frame kind");

  // Light update flag goes with bright frames only
  a_light_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[2] == (m_tuser[1:0] == KIND_BRIGHT)))
    else $error("light update flag does not match kind");

  // A finished summary always lands in the output register
  a_res_loaded: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> m_tvalid)
    else $error("summary lost");

endmodule

// ===== hw/rtl/sfr_parser.sv =====
// Frame parser: header hunt, payload capture and frame summary on the trailer.
module sfr_parser
  import sfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,     // a byte transfer completes this cycle
  input  logic [7:0] rx_byte,
  output logic       res_valid,  // summary is ready with this transfer
  output result_t    res
);

  phase_t     phase, phase_next;
  logic [7:0] remaining, remaining_next;
  logic [7:0] stored_count, stored_count_next;
  logic [7:0] kind_byte, kind_byte_next;
  logic [7:0] head [HEAD_DEPTH];
  logic [7:0] head_next [HEAD_DEPTH];

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT_S;
      remaining    <= '0;
      stored_count <= '0;
      kind_byte    <= '0;
      for (int i = 0; i < HEAD_DEPTH; i++) begin
        head[i] <= '0;
      end
    end else begin
      phase        <= phase_next;
      remaining    <= remaining_next;
      stored_count <= stored_count_next;
      kind_byte    <= kind_byte_next;
      for (int i = 0; i < HEAD_DEPTH; i++) begin
        head[i] <= head_next[i];
      end
    end
  end

  // Next state and frame summary
  always_comb begin
    logic [7:0] hi_nib;
    logic [7:0] lo_nib;
    phase_next        = phase;
    remaining_next    = remaining;
    stored_count_next = stored_count;
    kind_byte_next    = kind_byte;
    for (int i = 0; i < HEAD_DEPTH; i++) begin
      head_next[i] = head[i];
    end
    hi_nib = {4'b0, rx_byte[7:4] & NIB_MASK};
    lo_nib = {4'b0, rx_byte[3:0] & NIB_MASK};

    res_valid         = 1'b0;
    res.kind          = KIND_BRIGHT;
    if (kind_byte == TYPE_ORDER) begin
      res.kind = KIND_ORDER;
    end else if (kind_byte == TYPE_CMD) begin
      res.kind = KIND_CMD;
    end
    res.light_update  = (res.kind == KIND_BRIGHT);
    res.entry_count   = stored_count;
    res.trailer_value = rx_byte;
    res.light_id      = head[0];
    res.light_level   = head[1];
    res.light_offset  = head[2];

    if (accept) begin
      unique case (phase)
        PH_HUNT_S: begin
          phase_next = (rx_byte == SYNC_S) ? PH_WANT_T : PH_HUNT_S;
        end
        PH_WANT_T: begin
          // a broken header is not rechecked as a new S
          phase_next = (rx_byte == SYNC_T) ? PH_TYPE : PH_HUNT_S;
        end
        PH_TYPE: begin
          kind_byte_next = rx_byte;
          phase_next     = PH_LEN;
        end
        PH_LEN: begin
          remaining_next    = rx_byte;
          stored_count_next = '0;
          for (int i = 0; i < HEAD_DEPTH; i++) begin
            head_next[i] = '0;
          end
          phase_next = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (remaining == '0) begin
            // zero length: drop this byte
            phase_next = PH_HUNT_S;
          end else if (kind_byte == TYPE_ORDER) begin
            // high nibble first, low nibble only if still expected
            if (stored_count < HEAD_LIMIT) begin
              head_next[stored_count[1:0]] = hi_nib;
            end
            stored_count_next = stored_count + 8'd1;
            remaining_next    = remaining - 8'd1;
            if (remaining_next != '0) begin
              if (stored_count_next < HEAD_LIMIT) begin
                head_next[stored_count_next[1:0]] = lo_nib;
              end
              stored_count_next = stored_count_next + 8'd1;
              remaining_next    = remaining_next - 8'd1;
            end
            if (remaining_next == '0) begin
              phase_next = PH_TRAILER;
            end
          end else if (kind_byte == TYPE_CMD || kind_byte == TYPE_BRIGHT) begin
            if (stored_count < HEAD_LIMIT) begin
              head_next[stored_count[1:0]] = rx_byte;
            end
            stored_count_next = stored_count + 8'd1;
            remaining_next    = remaining - 8'd1;
            if (remaining_next == '0) begin
              phase_next = PH_TRAILER;
            end
          end else begin
            // unknown type: give up on this frame
            phase_next = PH_HUNT_S;
          end
        end
        PH_TRAILER: begin
          res_valid  = 1'b1;
          phase_next = PH_HUNT_S;
        end
        default: begin
          phase_next = PH_HUNT_S;
        end
      endcase
    end
  end

  // A summary only comes out of an accepted trailer byte
  a_res_on_trailer: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (accept && phase == PH_TRAILER))
    else $error("summary outside trailer phase");

  // The trailer is reached only once the payload is used up
  a_trailer_empty: assert property (@(posedge clk) disable iff (rst)
    phase == PH_TRAILER |-> remaining == '0)
    else $error("trailer with payload outstanding");

  // Payload phase is entered only from the length byte
  a_payload_entry: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_PAYLOAD) ##1 (phase == PH_PAYLOAD) |->
      ($past(phase) == PH_LEN && $past(remaining_next) == remaining))
    else $error("payload phase entered without length byte");

endmodule

// ===== tb/st_frame_receiver_test.sv =====
// Self-checking testbench for st_frame_receiver: byte stream in, frame summaries checked.
`timescale 1ns / 1ps

module st_frame_receiver_test;
  import sfr_pkg::*;

  // Tracks the frame parser and holds the summaries it owes
  class frame_tracker;
    phase_t      phase;
    logic [7:0]  left;
    logic [7:0]  stored;
    logic [7:0]  type_byte;
    logic [7:0]  head [HEAD_DEPTH];
    result_t     due_summaries [$];
    int unsigned errors;

    function void restart();
      phase     = PH_HUNT_S;
      left      = '0;
      stored    = '0;
      type_byte = '0;
      foreach (head[i]) head[i] = '0;
      due_summaries.delete();
      errors    = 0;
    endfunction

    function void keep(logic [7:0] v);
      if (stored < HEAD_LIMIT) head[stored] = v;
      stored = stored + 8'd1;
      left   = left - 8'd1;
    endfunction

    // Advance the parser by one accepted byte
    function void take_byte(logic [7:0] b);
      result_t sum;
      case (phase)
        PH_HUNT_S: phase = (b == SYNC_S) ? PH_WANT_T : PH_HUNT_S;
        PH_WANT_T: phase = (b == SYNC_T) ? PH_TYPE : PH_HUNT_S;
        PH_TYPE: begin
          type_byte = b;
          phase     = PH_LEN;
        end
        PH_LEN: begin
          left   = b;
          stored = '0;
          foreach (head[i]) head[i] = '0;
          phase  = PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (left == 0) begin
            // zero length: this byte is dropped
            phase = PH_HUNT_S;
          end else if (type_byte == TYPE_ORDER) begin
            // high nibble first, low nibble only if still wanted
            keep({4'h0, b[7:4] & NIB_MASK});
            if (left != 0) keep({4'h0, b[3:0] & NIB_MASK});
            if (left == 0) phase = PH_TRAILER;
          end else if (type_byte == TYPE_CMD || type_byte == TYPE_BRIGHT) begin
            keep(b);
            if (left == 0) phase = PH_TRAILER;
          end else begin
            // unknown type: drop and go back to hunting
            phase = PH_HUNT_S;
          end
        end
        PH_TRAILER: begin
          if (type_byte == TYPE_ORDER) sum.kind = KIND_ORDER;
          else if (type_byte == TYPE_CMD) sum.kind = KIND_CMD;
          else sum.kind = KIND_BRIGHT;
          sum.light_update  = (sum.kind == KIND_BRIGHT);
          sum.entry_count   = stored;
          sum.trailer_value = b;
          sum.light_id      = head[0];
          sum.light_level   = head[1];
          sum.light_offset  = head[2];
          due_summaries.push_back(sum);
          phase = PH_HUNT_S;
        end
        default: phase = PH_HUNT_S;
      endcase
    endfunction

    task flag_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    task field_check(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        flag_mismatch($sformatf("%s got 0x%02h want 0x%02h", name, got, want));
    endtask

    // Compare one summary transfer with the oldest owed summary
    task match_summary(logic [39:0] d, logic [2:0] u);
      result_t want;
      if (due_summaries.size() == 0) begin
        flag_mismatch($sformatf("unexpected summary data=0x%010h user=0x%0h", d, u));
        return;
      end
      want = due_summaries.pop_front();
      field_check("frame_kind", {6'd0, u[1:0]}, {6'd0, want.kind});
      field_check("light_update", {7'd0, u[2]}, {7'd0, want.light_update});
      field_check("entry_count", d[7:0], want.entry_count);
      field_check("trailer_value", d[15:8], want.trailer_value);
      field_check("light_id", d[23:16], want.light_id);
      field_check("light_level", d[31:24], want.light_level);
      field_check("light_offset", d[39:32], want.light_offset);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [2:0]  m_tuser;

  frame_tracker tracker = new();
  bit           calm = 1'b0;   // no idling on either side while set
  int unsigned  sent_bytes = 0;

  st_frame_receiver DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #10 clk = ~clk;

  // Run limit
  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Output side: random back-pressure, checked at the rising edge
  always @(negedge clk) begin
    m_tready = calm || ($urandom_range(99) >= 35);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.match_summary(m_tdata, m_tuser);
  end

  // One byte transfer; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 35) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    do @(posedge clk); while (!s_tready);
    tracker.take_byte(b);
    sent_bytes++;
    @(negedge clk);
  endtask

  // Header, length, payload and trailer; optionally cut short
  task automatic send_frame(input logic [7:0] ty, input logic [7:0] len, input bit cut);
    logic [7:0] bytes [$];
    int         nbytes;
    nbytes = (ty == TYPE_ORDER) ? (int'(len) + 1) / 2 : int'(len);
    bytes = '{SYNC_S, SYNC_T, ty, len};
    repeat (nbytes) bytes.push_back(8'($urandom_range(255)));
    // trailer, or the dropped byte after a zero length
    bytes.push_back(8'($urandom_range(255)));
    if (cut) begin
      while (bytes.size() > 1 && $urandom_range(3) != 0) void'(bytes.pop_back());
    end
    foreach (bytes[i]) send_byte(bytes[i]);
  endtask

  function automatic logic [7:0] pick_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 1) return 8'd255;
    if (r < 4) return 8'($urandom_range(255));
    return 8'($urandom_range(7));
  endfunction

  function automatic logic [7:0] pick_type();
    case ($urandom_range(2))
      0:       return TYPE_ORDER;
      1:       return TYPE_CMD;
      default: return TYPE_BRIGHT;
    endcase
  endfunction

  initial begin
    logic [7:0]  directed [];
    int unsigned pick;

    directed = '{
      // order frame, odd nibble count, all-ones trailer
      SYNC_S, SYNC_T, TYPE_ORDER, 8'h03, 8'hAB, 8'hCD, 8'hFF,
      // zero length drops the next byte
      SYNC_S, SYNC_T, TYPE_CMD, 8'h00, 8'h77,
      // bright frame with one entry, unreceived fields read zero
      SYNC_S, SYNC_T, TYPE_BRIGHT, 8'h01, 8'hFF, 8'h00,
      // broken header: second S is not rescanned
      SYNC_S, SYNC_S, SYNC_T,
      // unknown type returns to hunting
      SYNC_S, SYNC_T, 8'h00, 8'h02, SYNC_S
    };

    tracker.restart();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed[i]) send_byte(directed[i]);

    // Random part: mostly well-formed frames, some noise and broken frames
    while (sent_bytes < 1926) begin
      calm = (sent_bytes >= 800 && sent_bytes < 1100);
      pick = $urandom_range(99);
      if (pick < 75) begin
        send_frame(pick_type(), pick_len(), 1'b0);
      end else if (pick < 83) begin
        send_frame(8'($urandom_range(255)), pick_len(), 1'b0);
      end else if (pick < 91) begin
        send_frame(pick_type(), pick_len(), 1'b1);
      end else begin
        repeat ($urandom_range(1, 6))
          send_byte(($urandom_range(5) == 0) ? SYNC_S : 8'($urandom_range(255)));
      end
    end
    calm     = 1'b0;
    s_tvalid = 1'b0;

    // Drain owed summaries, then let the output stage settle
    while (tracker.due_summaries.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (tracker.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_parser.sv
hw/rtl/st_frame_receiver.sv
tb/st_frame_receiver_test.sv
